FILE: rtl/tsrt_pkg.sv
// Shared constants and types of the TCP segment reassembly tracker.
// No dependencies; used by tcp_segment_reassembly_tracker.
package tsrt_pkg;

  localparam int unsigned FlowsDefault = 64;
  localparam int unsigned HoldsDefault = 16;

  localparam int unsigned CapW = 23;
  localparam logic [CapW-1:0] StreamCapReset = 23'd4194304;
  localparam logic [7:0] SynMask = 8'h02;

  // Held segment as stored in the hold memory
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] tag;
  } hold_ent_t;

endpackage

FILE: rtl/tcp_segment_reassembly_tracker.sv
// TCP segment reassembly tracker: flow lookup, half-stream state and hold slots.
// Depends on tsrt_pkg; flow, half and hold state live in three local memories.
//
//  channel   signals                                      handshake
//  segment   start, busy, source_ip_i .. payload_tag_i    taken when start & !busy
//  result    out_valid_o, flow_slot_o .. last_o           one-cycle strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata, ...    APB, pready always high
//
// A segment keeps busy high through lookup, half-state load, decision and write-back; a new
// flow is allocated after the flow table scan, and a segment that finds the table full is
// dropped. Drain scans, hold inserts and hold removals extend the busy time; the single
// read port of the hold memory and the flow table scan set its length.
// Reset clears control state only; memories hold no data until written.
// Each result waits in a one-deep pending register until the next result or the end of
// the segment, so last is known; the final one leaves in the same cycle that busy falls.
module tcp_segment_reassembly_tracker #(
  parameter int unsigned FLOWS = tsrt_pkg::FlowsDefault,
  parameter int unsigned HOLDS = tsrt_pkg::HoldsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [7:0]  flags_i,
  input  logic [15:0] payload_length_i,
  input  logic [15:0] payload_tag_i,
  output logic        out_valid_o,
  output logic [5:0]  flow_slot_o,
  output logic        direction_o,
  output logic [15:0] delivered_tag_o,
  output logic [15:0] skip_bytes_o,
  output logic [15:0] deliver_length_o,
  output logic [22:0] stream_length_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned FIW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int unsigned FCW = $clog2(FLOWS + 1);
  localparam int unsigned HW  = FIW + 1;
  localparam int unsigned HIW = (HOLDS > 1) ? $clog2(HOLDS) : 1;
  localparam int unsigned HCW = $clog2(HOLDS + 1);
  localparam int unsigned HAW = $clog2(2 * FLOWS * HOLDS);
  localparam int unsigned CW  = tsrt_pkg::CapW;

  typedef struct packed {
    logic           st;
    logic [31:0]    nx;
    logic [CW-1:0]  sb;
    logic [HCW-1:0] hc;
  } half_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_ALLOC, S_HREAD, S_HLOAD, S_PROC, S_ADDSCAN,
    S_DRAIN, S_REMRD, S_REMWR, S_APPEND, S_WB, S_FIN
  } state_e;

  // Memories
  logic [95:0]         flow_mem [FLOWS];
  half_t               half_mem [2*FLOWS];
  tsrt_pkg::hold_ent_t hold_mem [2*FLOWS*HOLDS];

  logic                flow_we;
  logic [FIW-1:0]      flow_wa, flow_ra;
  logic [95:0]         flow_wd, flow_rd_q;
  logic                half_we;
  logic [HW-1:0]       half_wa, half_ra;
  half_t               half_wd, half_rd_q;
  logic                hold_we;
  logic [HAW-1:0]      hold_wa, hold_ra;
  tsrt_pkg::hold_ent_t hold_wd, hold_rd_q;

  // Control and working registers
  state_e         state_q, state_d;
  logic [CW-1:0]  cap_q;
  logic [FCW-1:0] flow_cnt_q, flow_cnt_d;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [FIW-1:0] fridx_q, fridx_d;
  logic           fpend_q, fpend_d;
  logic [HCW-1:0] hcnt_q, hcnt_d;
  logic [HIW-1:0] hridx_q, hridx_d;
  logic           hpend_q, hpend_d;
  logic [HIW-1:0] remidx_q, remidx_d;
  logic           ret_add_q, ret_add_d;
  logic [HIW-1:0] worst_q, worst_d;
  logic [31:0]    wseq_q, wseq_d;
  logic [FIW-1:0] slot_q, slot_d;
  logic [31:0]    hn_q, hn_d;
  logic [CW-1:0]  hs_q, hs_d;
  logic [HCW-1:0] hc_q, hc_d;
  logic           pvld_q, pvld_d;
  logic           ovld_q, ovld_d;

  // Latched segment
  logic [31:0] aip_q, bip_q, ports_q, seq_q;
  logic        dir_q, syn_q;
  logic [15:0] plen_q, tag_q;

  // Pending and output result payload
  logic [15:0]   ptag_q, ptag_d, pskip_q, pskip_d, plen_out_q, plen_out_d;
  logic [CW-1:0] ptot_q, ptot_d;
  logic [15:0]   otag_q, otag_d, oskip_q, oskip_d, olen_q, olen_d;
  logic [CW-1:0] otot_q, otot_d;
  logic          olast_q, olast_d;
  logic [FIW-1:0] oslot_q;
  logic          odir_q;

  logic        accept, from_a, flow_match;
  logic [HAW-1:0] hbase;
  logic [31:0] diff, already, dd, wdiff;
  logic        push;
  logic [15:0] push_tag, push_skip, push_len;
  logic [CW-1:0] push_tot;

  function automatic logic [CW-1:0] grow(input logic [CW-1:0] old, input logic [15:0] n,
                                         input logic [CW-1:0] cap);
    logic [CW:0] s;
    s = {1'b0, old} + (CW+1)'(n);
    if (s > {1'b0, cap}) begin
      s = (cap > old) ? {1'b0, cap} : {1'b0, old};
    end
    return s[CW-1:0];
  endfunction

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign from_a = (source_ip_i < dest_ip_i) ||
                  ((source_ip_i == dest_ip_i) && (source_port_i <= dest_port_i));
  assign flow_match = (flow_rd_q == {aip_q, bip_q, ports_q});
  assign hbase   = HAW'({slot_q, dir_q}) * HAW'(HOLDS);
  assign diff    = seq_q - hn_q;
  assign already = hn_q - seq_q;
  assign dd      = hold_rd_q.seq + 32'(hold_rd_q.len) - hn_q;
  assign wdiff   = hold_rd_q.seq - wseq_q;

  // Sequencer: lookup, flow allocation, half-state load, deliver, drain, hold insert and removal
  always_comb begin
    state_d    = state_q;
    flow_cnt_d = flow_cnt_q;
    fcnt_d     = fcnt_q;
    fridx_d    = fridx_q;
    fpend_d    = 1'b0;
    hcnt_d     = hcnt_q;
    hridx_d    = hridx_q;
    hpend_d    = 1'b0;
    remidx_d   = remidx_q;
    ret_add_d  = ret_add_q;
    worst_d    = worst_q;
    wseq_d     = wseq_q;
    slot_d     = slot_q;
    hn_d       = hn_q;
    hs_d       = hs_q;
    hc_d       = hc_q;
    flow_we    = 1'b0;
    flow_wa    = flow_cnt_q[FIW-1:0];
    flow_wd    = {aip_q, bip_q, ports_q};
    flow_ra    = fcnt_q[FIW-1:0];
    half_we    = 1'b0;
    half_wa    = {slot_q, dir_q};
    half_wd    = '{st: 1'b1, nx: hn_q, sb: hs_q, hc: hc_q};
    half_ra    = {slot_q, dir_q};
    hold_we    = 1'b0;
    hold_wa    = hbase + HAW'(remidx_q);
    hold_wd    = hold_rd_q;
    hold_ra    = hbase + HAW'(hcnt_q);
    push       = 1'b0;
    push_tag   = tag_q;
    push_skip  = 16'd0;
    push_len   = plen_q;
    push_tot   = grow(hs_q, plen_q, cap_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fcnt_d  = '0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (fpend_q && flow_match) begin
          slot_d  = fridx_q;
          state_d = S_HREAD;
        end else if (fcnt_q < flow_cnt_q) begin
          fridx_d = fcnt_q[FIW-1:0];
          fcnt_d  = fcnt_q + FCW'(1);
          fpend_d = 1'b1;
        end else if (flow_cnt_q == FCW'(FLOWS)) begin
          // table full: drop the segment
          state_d = S_FIN;
        end else begin
          flow_we    = 1'b1;
          slot_d     = flow_cnt_q[FIW-1:0];
          flow_cnt_d = flow_cnt_q + FCW'(1);
          state_d    = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // clear the opposite half, anchor this one
        half_we = 1'b1;
        half_wa = {slot_q, ~dir_q};
        half_wd = '{st: 1'b0, nx: 32'd0, sb: '0, hc: '0};
        hn_d    = seq_q + {31'd0, syn_q};
        hs_d    = '0;
        hc_d    = '0;
        state_d = S_PROC;
      end
      S_HREAD: begin
        state_d = S_HLOAD;
      end
      S_HLOAD: begin
        if (half_rd_q.st) begin
          hn_d = half_rd_q.nx;
          hs_d = half_rd_q.sb;
          hc_d = half_rd_q.hc;
        end else begin
          hn_d = seq_q + {31'd0, syn_q};
          hs_d = '0;
          hc_d = '0;
        end
        state_d = S_PROC;
      end
      S_PROC: begin
        hcnt_d = '0;
        if (plen_q == 16'd0) begin
          state_d = S_WB;
        end else if (diff == 32'd0) begin
          push    = 1'b1;
          hs_d    = push_tot;
          hn_d    = hn_q + 32'(plen_q);
          state_d = S_DRAIN;
        end else if (!diff[31]) begin
          state_d = S_ADDSCAN;
        end else if (already < 32'(plen_q)) begin
          push      = 1'b1;
          push_skip = already[15:0];
          push_len  = plen_q - already[15:0];
          push_tot  = grow(hs_q, push_len, cap_q);
          hs_d      = push_tot;
          hn_d      = hn_q + 32'(push_len);
          state_d   = S_DRAIN;
        end else begin
          state_d = S_WB;
        end
      end
      S_DRAIN: begin
        if (hpend_q && (hold_rd_q.seq == hn_q)) begin
          push      = 1'b1;
          push_tag  = hold_rd_q.tag;
          push_len  = hold_rd_q.len;
          push_tot  = grow(hs_q, hold_rd_q.len, cap_q);
          hs_d      = push_tot;
          hn_d      = hn_q + 32'(hold_rd_q.len);
          remidx_d  = hridx_q;
          ret_add_d = 1'b0;
          state_d   = S_REMRD;
        end else if (hpend_q && ((dd == 32'd0) || dd[31])) begin
          // fully consumed: drop without delivery
          remidx_d  = hridx_q;
          ret_add_d = 1'b0;
          state_d   = S_REMRD;
        end else if (hcnt_q < hc_q) begin
          hridx_d = hcnt_q[HIW-1:0];
          hcnt_d  = hcnt_q + HCW'(1);
          hpend_d = 1'b1;
        end else begin
          state_d = S_WB;
        end
      end
      S_ADDSCAN: begin
        if (hpend_q && (hold_rd_q.seq == seq_q)) begin
          // duplicate: ignore
          state_d = S_WB;
        end else begin
          if (hpend_q) begin
            if (hridx_q == '0) begin
              worst_d = '0;
              wseq_d  = hold_rd_q.seq;
            end else if ((wdiff != 32'd0) && !wdiff[31]) begin
              worst_d = hridx_q;
              wseq_d  = hold_rd_q.seq;
            end
          end
          if (hcnt_q < hc_q) begin
            hridx_d = hcnt_q[HIW-1:0];
            hcnt_d  = hcnt_q + HCW'(1);
            hpend_d = 1'b1;
          end else if (!hpend_q) begin
            if (hc_q == HCW'(HOLDS)) begin
              remidx_d  = worst_q;
              ret_add_d = 1'b1;
              state_d   = S_REMRD;
            end else begin
              state_d = S_APPEND;
            end
          end
        end
      end
      S_REMRD: begin
        // fetch the last slot to move into the freed one
        hc_d    = hc_q - HCW'(1);
        hold_ra = hbase + HAW'(hc_d);
        state_d = S_REMWR;
      end
      S_REMWR: begin
        hold_we = 1'b1;
        hcnt_d  = '0;
        state_d = ret_add_q ? S_APPEND : S_DRAIN;
      end
      S_APPEND: begin
        hold_we = 1'b1;
        hold_wa = hbase + HAW'(hc_q);
        hold_wd = '{seq: seq_q, len: plen_q, tag: tag_q};
        hc_d    = hc_q + HCW'(1);
        state_d = S_WB;
      end
      S_WB: begin
        half_we = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result staging: hold one result back until the next or the end is known
  always_comb begin
    pvld_d     = pvld_q;
    ptag_d     = ptag_q;
    pskip_d    = pskip_q;
    plen_out_d = plen_out_q;
    ptot_d     = ptot_q;
    ovld_d     = 1'b0;
    otag_d     = ptag_q;
    oskip_d    = pskip_q;
    olen_d     = plen_out_q;
    otot_d     = ptot_q;
    olast_d    = 1'b0;
    if (push) begin
      ovld_d     = pvld_q;
      pvld_d     = 1'b1;
      ptag_d     = push_tag;
      pskip_d    = push_skip;
      plen_out_d = push_len;
      ptot_d     = push_tot;
    end else if (state_q == S_FIN) begin
      ovld_d  = pvld_q;
      olast_d = 1'b1;
      pvld_d  = 1'b0;
    end
  end

  // Control state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cap_q      <= tsrt_pkg::StreamCapReset;
      flow_cnt_q <= '0;
      fpend_q    <= 1'b0;
      hpend_q    <= 1'b0;
      pvld_q     <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      flow_cnt_q <= flow_cnt_d;
      fpend_q    <= fpend_d;
      hpend_q    <= hpend_d;
      pvld_q     <= pvld_d;
      ovld_q     <= ovld_d;
      if (psel && penable && pwrite) begin
        cap_q <= pwdata[CW-1:0];
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    fcnt_q     <= fcnt_d;
    fridx_q    <= fridx_d;
    hcnt_q     <= hcnt_d;
    hridx_q    <= hridx_d;
    remidx_q   <= remidx_d;
    ret_add_q  <= ret_add_d;
    worst_q    <= worst_d;
    wseq_q     <= wseq_d;
    slot_q     <= slot_d;
    hn_q       <= hn_d;
    hs_q       <= hs_d;
    hc_q       <= hc_d;
    ptag_q     <= ptag_d;
    pskip_q    <= pskip_d;
    plen_out_q <= plen_out_d;
    ptot_q     <= ptot_d;
    otag_q     <= otag_d;
    oskip_q    <= oskip_d;
    olen_q     <= olen_d;
    otot_q     <= otot_d;
    olast_q    <= olast_d;
    oslot_q    <= slot_q;
    odir_q     <= dir_q;
    if (accept) begin
      aip_q   <= from_a ? source_ip_i : dest_ip_i;
      bip_q   <= from_a ? dest_ip_i : source_ip_i;
      ports_q <= from_a ? {source_port_i, dest_port_i} : {dest_port_i, source_port_i};
      dir_q   <= ~from_a;
      seq_q   <= seq_number_i;
      syn_q   <= |(flags_i & tsrt_pkg::SynMask);
      plen_q  <= payload_length_i;
      tag_q   <= payload_tag_i;
    end
  end

  // Flow table memory
  always_ff @(posedge clk_i) begin
    if (flow_we) begin
      flow_mem[flow_wa] <= flow_wd;
    end
    flow_rd_q <= flow_mem[flow_ra];
  end

  // Half-stream state memory
  always_ff @(posedge clk_i) begin
    if (half_we) begin
      half_mem[half_wa] <= half_wd;
    end
    half_rd_q <= half_mem[half_ra];
  end

  // Hold slot memory
  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      hold_mem[hold_wa] <= hold_wd;
    end
    hold_rd_q <= hold_mem[hold_ra];
  end

  assign out_valid_o      = ovld_q;
  assign flow_slot_o      = 6'(oslot_q);
  assign direction_o      = odir_q;
  assign delivered_tag_o  = otag_q;
  assign skip_bytes_o     = oskip_q;
  assign deliver_length_o = olen_q;
  assign stream_length_o  = otot_q;
  assign last_o           = olast_q;
  assign prdata           = {{(32-CW){1'b0}}, cap_q};
  assign pready           = 1'b1;

endmodule
